>>> sv/mpts_pkg.sv
// shared constants, codes and types for the midi pulse tone synth
package mpts_pkg;

  // sizes
  localparam int CHANNELS     = 2;
  localparam int VOICES       = 2;
  localparam int COUNT_BITS   = 16;
  localparam int PERIOD_BITS  = 16;
  localparam int DUTY_BITS    = 8;
  localparam int NOTE_BITS    = 7;
  localparam int TABLE_DEPTH  = 128;
  localparam int CMP_BITS     = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
  localparam int VOICE_TOTAL  = CHANNELS * VOICES;
  localparam int VIDX_BITS    = $clog2(VOICE_TOTAL);
  localparam int CH_BITS      = $clog2(CHANNELS);

  // stream widths
  localparam int IN_BITS      = 40;
  localparam int OUT_BITS     = 8;

  // register reset values
  localparam logic [DUTY_BITS-1:0] DUTY_RESET = DUTY_BITS'(10);

  // input opcodes
  localparam logic [1:0] OP_MIDI  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_TABLE = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_DUTY_CH0   = 2'd0;
  localparam logic [1:0] REG_DUTY_CH1   = 2'd1;
  localparam logic [1:0] REG_ENABLE_CH0 = 2'd2;
  localparam logic [1:0] REG_ENABLE_CH1 = 2'd3;

  // midi status nibbles
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

  // voice bank commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CH_BITS-1:0]   ch;
    logic [NOTE_BITS-1:0] note;
  } cmd_t;

endpackage

>>> sv/midi_pulse_tone_synth.sv
// top level: midi parser, period table memory, command stage and output register
// a tick transaction's drive levels pass through the command stage and then the output register
// throughput: one input transaction per cycle; only an unaccepted tick result stalls input
// the note period comes from a registered synchronous table read, applied in the command stage
// reset: synchronous rst clears parser, voices, config registers and valid flags; the period table is not cleared
// and must be written before a note that uses an entry is started
module midi_pulse_tone_synth (
  input  logic                               clk,
  input  logic                               rst,
  // opcode[1:0], midi_byte[9:2], table_index[16:10], table_value[32:17], zero pad
  input  logic [mpts_pkg::IN_BITS-1:0]       s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // drive_ch0[0], drive_ch1[1], zero pad
  output logic [mpts_pkg::OUT_BITS-1:0]      m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mpts_pkg::DUTY_BITS-1:0]     cfg_data
);
  import mpts_pkg::*;

  // input fields
  logic [1:0]             in_opcode;
  logic [7:0]             in_byte;
  logic [NOTE_BITS-1:0]   in_index;
  logic [PERIOD_BITS-1:0] in_value;
  logic                   accept;

  // config registers
  logic [CHANNELS-1:0][DUTY_BITS-1:0] duty;
  logic [CHANNELS-1:0]                enable;

  // parser state
  logic                 mode_on;
  logic [3:0]           cur_ch;
  logic                 expect_second;
  logic [NOTE_BITS-1:0] held_note;
  cmd_t                 cmd_next;

  // command stage and table
  logic                   s1_valid;
  cmd_t                   s1_cmd;
  logic                   s1_fire;
  logic [PERIOD_BITS-1:0] period_mem [TABLE_DEPTH];
  logic [PERIOD_BITS-1:0] period_rd;
  logic [CHANNELS-1:0]    tick_drive;

  assign in_opcode = s_tdata[1:0];
  assign in_byte   = s_tdata[9:2];
  assign in_index  = s_tdata[16:10];
  assign in_value  = s_tdata[32:17];
  assign accept    = s_tvalid && s_tready;

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      duty   <= {CHANNELS{DUTY_RESET}};
      enable <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DUTY_CH0:   duty[0]   <= cfg_data;
        REG_DUTY_CH1:   duty[1]   <= cfg_data;
        REG_ENABLE_CH0: enable[0] <= cfg_data[0];
        REG_ENABLE_CH1: enable[1] <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // decode the accepted transaction into a voice command
  always_comb begin
    cmd_next.kind = CMD_NONE;
    cmd_next.ch   = cur_ch[CH_BITS-1:0];
    cmd_next.note = held_note;
    if (in_opcode == OP_TICK) begin
      cmd_next.kind = CMD_TICK;
    end else if (in_opcode == OP_MIDI && !in_byte[7] && expect_second &&
                 cur_ch < 4'(CHANNELS)) begin
      cmd_next.kind = (mode_on && in_byte != 8'd0) ? CMD_START : CMD_STOP;
    end
  end

  // running status and data byte pairing
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_on       <= 1'b1;
      cur_ch        <= '0;
      expect_second <= 1'b0;
      held_note     <= '0;
    end else if (accept && in_opcode == OP_MIDI) begin
      if (in_byte[7:4] == STATUS_NOTE_ON || in_byte[7:4] == STATUS_NOTE_OFF) begin
        mode_on <= (in_byte[7:4] == STATUS_NOTE_ON);
        cur_ch  <= in_byte[3:0];
      end else if (!in_byte[7]) begin
        if (!expect_second) begin
          held_note     <= in_byte[NOTE_BITS-1:0];
          expect_second <= 1'b1;
        end else begin
          expect_second <= 1'b0;
        end
      end
    end
  end

  // period table: write on table transactions, read the held note on every accept
  always_ff @(posedge clk) begin
    if (accept && in_opcode == OP_TABLE) begin
      period_mem[in_index] <= in_value;
    end
    if (accept) begin
      period_rd <= period_mem[held_note];
    end
  end

  // command stage, stalls only when a tick result cannot be stored
  assign s1_fire  = s1_valid && (s1_cmd.kind != CMD_TICK || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd_next;
    end
  end

  mpts_voice_bank u_voices (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (s1_fire),
    .cmd        (s1_cmd),
    .period_in  (period_rd),
    .duty       (duty),
    .enable     (enable),
    .tick_drive (tick_drive)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_cmd.kind == CMD_TICK) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cmd.kind == CMD_TICK) begin
      m_tdata <= {(OUT_BITS-CHANNELS)'(0), tick_drive};
    end
  end

endmodule

>>> sv/mpts_voice_bank.sv
// voice state registers, note start/stop and per-tick pulse generation
module mpts_voice_bank (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cmd_valid,
  input  mpts_pkg::cmd_t                                cmd,
  input  logic [mpts_pkg::PERIOD_BITS-1:0]              period_in,
  input  logic [mpts_pkg::CHANNELS-1:0][mpts_pkg::DUTY_BITS-1:0] duty,
  input  logic [mpts_pkg::CHANNELS-1:0]                 enable,
  output logic [mpts_pkg::CHANNELS-1:0]                 tick_drive
);
  import mpts_pkg::*;

  logic [VOICE_TOTAL-1:0]                  active;
  logic [VOICE_TOTAL-1:0][NOTE_BITS-1:0]   note;
  logic [VOICE_TOTAL-1:0][COUNT_BITS-1:0]  count;
  logic [VOICE_TOTAL-1:0][PERIOD_BITS-1:0] period;
  logic [CHANNELS-1:0]                     last_used;
  logic [CHANNELS-1:0]                     drive;

  logic [VOICE_TOTAL-1:0][COUNT_BITS-1:0]  count_inc;
  logic [VOICE_TOTAL-1:0][COUNT_BITS-1:0]  count_next;
  logic [VOICE_TOTAL-1:0]                  voice_high;
  logic [VIDX_BITS-1:0]                    start_idx;
  logic [VIDX_BITS-1:0]                    stop_idx0;
  logic [VIDX_BITS-1:0]                    stop_idx1;
  logic                                    match0;
  logic                                    match1;

  // per-voice counter step and pulse level
  always_comb begin
    for (int i = 0; i < VOICE_TOTAL; i++) begin
      count_inc[i]  = count[i] + COUNT_BITS'(1);
      voice_high[i] = active[i] &&
                      (CMP_BITS'(count_inc[i]) < CMP_BITS'(duty[i / VOICES]));
      count_next[i] = (CMP_BITS'(count_inc[i]) > CMP_BITS'(period[i]))
                      ? '0 : count_inc[i];
    end
  end

  // channel drive is the xor of its voices, held when disabled
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      tick_drive[c] = enable[c] ? (voice_high[c*VOICES] ^ voice_high[c*VOICES+1])
                                : drive[c];
    end
  end

  // voice selection for note events
  always_comb begin
    start_idx = {cmd.ch, ~last_used[cmd.ch]};
    stop_idx0 = {cmd.ch, 1'b0};
    stop_idx1 = {cmd.ch, 1'b1};
    match0    = (note[stop_idx0] == cmd.note);
    match1    = (note[stop_idx1] == cmd.note);
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      note      <= '0;
      count     <= '0;
      last_used <= '0;
      drive     <= '0;
    end else if (cmd_valid) begin
      unique case (cmd.kind)
        CMD_START: begin
          last_used[cmd.ch] <= ~last_used[cmd.ch];
          active[start_idx] <= 1'b1;
          note[start_idx]   <= cmd.note;
          count[start_idx]  <= '0;
        end
        CMD_STOP: begin
          if (match0) begin
            active[stop_idx0] <= 1'b0;
          end
          if (match1) begin
            active[stop_idx1] <= 1'b0;
          end
          // later voice decides the marker
          if (match1) begin
            last_used[cmd.ch] <= 1'b0;
          end else if (match0) begin
            last_used[cmd.ch] <= 1'b1;
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < VOICE_TOTAL; i++) begin
            if (enable[i / VOICES] && active[i]) begin
              count[i] <= count_next[i];
            end
          end
          drive <= tick_drive;
        end
        default: begin
        end
      endcase
    end
  end

  // period is payload, loaded on note start
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd.kind == CMD_START) begin
      period[start_idx] <= period_in;
    end
  end

endmodule
